### hw/rtl/dhl_pkg.sv
// dhl_pkg: shared widths, constants, CORDIC table and arithmetic helpers
// for the link transform pipeline. No dependencies.
package dhl_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam int unsigned ANG_W     = 16;
  localparam int unsigned ANG_SHIFT = 17;
  localparam int unsigned CW        = ANG_W + ANG_SHIFT;
  localparam int unsigned LEN_W     = 24;
  localparam int unsigned TRIG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_JOINT_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_TWIST   = 2'd2;

  localparam logic signed [CW-1:0] GAIN_Q30    = CW'(64'sd652032874);
  localparam logic signed [CW:0]   PI_Q30      = (CW+1)'(64'sd3373259426);
  localparam logic signed [CW:0]   HALF_PI_Q30 = (CW+1)'(64'sd1686629713);

  localparam int TRIG_ONE = 16384;
  localparam int LEN_MAX  = 8388607;
  localparam int LEN_MIN  = -8388608;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } dhl_lane_t;

  typedef struct packed {
    dhl_lane_t th;
    dhl_lane_t al;
  } dhl_pair_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] rot_00;
    logic signed [TRIG_W-1:0] rot_01;
    logic signed [TRIG_W-1:0] rot_02;
    logic signed [TRIG_W-1:0] rot_10;
    logic signed [TRIG_W-1:0] rot_11;
    logic signed [TRIG_W-1:0] rot_12;
    logic signed [TRIG_W-1:0] rot_21;
    logic signed [TRIG_W-1:0] rot_22;
    logic signed [LEN_W-1:0]  pos_x;
    logic signed [LEN_W-1:0]  pos_y;
  } dhl_result_t;

  // atan(2^-i) in Q2.30
  function automatic logic signed [CW-1:0] dhl_atan(input logic [4:0] i);
    logic signed [CW-1:0] r;
    unique case (i)
      5'd0:    r = CW'(64'sd843314857);
      5'd1:    r = CW'(64'sd497837829);
      5'd2:    r = CW'(64'sd263043837);
      5'd3:    r = CW'(64'sd133525159);
      5'd4:    r = CW'(64'sd67021687);
      5'd5:    r = CW'(64'sd33543516);
      5'd6:    r = CW'(64'sd16775851);
      5'd7:    r = CW'(64'sd8388437);
      5'd8:    r = CW'(64'sd4194283);
      5'd9:    r = CW'(64'sd2097149);
      5'd10:   r = CW'(64'sd1048576);
      default: r = CW'(1) << (5'd30 - i);
    endcase
    return r;
  endfunction

  // widen to Q2.30 and fold into [-pi/2, pi/2]
  function automatic dhl_lane_t dhl_reduce(input logic signed [ANG_W-1:0] ang);
    logic signed [CW:0] z;
    dhl_lane_t          r;
    z     = $signed({ang, {ANG_SHIFT{1'b0}}});
    r.x   = GAIN_Q30;
    r.y   = '0;
    r.neg = 1'b0;
    if (z > HALF_PI_Q30) begin
      z     = z - PI_Q30;
      r.neg = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z     = z + PI_Q30;
      r.neg = 1'b1;
    end
    r.z = z[CW-1:0];
    return r;
  endfunction

  function automatic dhl_lane_t dhl_rotate(input dhl_lane_t l,
                                           input logic [STEP_W-1:0] step,
                                           input logic signed [CW-1:0] atan);
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dhl_lane_t            r;
    x  = l.x;
    y  = l.y;
    dx = y >>> step;
    dy = x >>> step;
    r  = l;
    if (!l.z[CW-1]) begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = l.z - atan;
    end else begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = l.z + atan;
    end
    return r;
  endfunction

  // Q2.30 -> Q1.14, round half up, clamp to +-1
  function automatic logic signed [TRIG_W-1:0] dhl_round_trig(input logic signed [CW-1:0] v,
                                                              input logic neg);
    logic signed [CW+1:0] w;
    logic signed [TRIG_W-1:0] r;
    w = (CW+2)'(v);
    if (neg) begin
      w = -w;
    end
    w = (w + (CW+2)'(32768)) >>> 16;
    if (w > TRIG_ONE) begin
      r = TRIG_W'(TRIG_ONE);
    end else if (w < -TRIG_ONE) begin
      r = TRIG_W'(-TRIG_ONE);
    end else begin
      r = w[TRIG_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [TRIG_W-1:0] dhl_rot_mul(input logic signed [TRIG_W-1:0] p,
                                                           input logic signed [TRIG_W-1:0] q,
                                                           input logic neg);
    logic signed [2*TRIG_W:0] w;
    logic signed [TRIG_W-1:0] r;
    w = (2*TRIG_W+1)'(p) * (2*TRIG_W+1)'(q);
    if (neg) begin
      w = -w;
    end
    w = (w + (2*TRIG_W+1)'(8192)) >>> 14;
    if (w > TRIG_ONE) begin
      r = TRIG_W'(TRIG_ONE);
    end else if (w < -TRIG_ONE) begin
      r = TRIG_W'(-TRIG_ONE);
    end else begin
      r = w[TRIG_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [LEN_W-1:0] dhl_len_mul(input logic signed [LEN_W-1:0] len,
                                                          input logic signed [TRIG_W-1:0] q);
    logic signed [LEN_W+TRIG_W:0] w;
    logic signed [LEN_W-1:0]      r;
    w = (LEN_W+TRIG_W+1)'(len) * (LEN_W+TRIG_W+1)'(q);
    w = (w + (LEN_W+TRIG_W+1)'(8192)) >>> 14;
    if (w > LEN_MAX) begin
      r = LEN_W'(LEN_MAX);
    end else if (w < LEN_MIN) begin
      r = LEN_W'(LEN_MIN);
    end else begin
      r = w[LEN_W-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/dh_link_transform.sv
// dh_link_transform: Denavit-Hartenberg link transform, top level.
// Uses dhl_pkg, dhl_front, dhl_cordic_cell, dhl_back.
//
//   channel  handshake              payload
//   in       in_valid_i/in_ready_o  joint_angle_i
//   out      out_valid_o/out_ready_i rot_00_o..rot_22_o, pos_x_o, pos_y_o, pos_z_o
//   cfg      cfg_we_i               cfg_idx_i, cfg_data_i
//
// One word per cycle sustained while out_ready_i is held high; the stages are
// input fold, one cell per CORDIC step, rounding, products.
// Every stage holds a word while the next is full, so bubbles close up
// and the output register stalls only what is behind it.
// Reset clears all valid bits and the three link registers.
module dh_link_transform import dhl_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ANG_W-1:0]  joint_angle_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [TRIG_W-1:0] rot_00_o,
  output logic signed [TRIG_W-1:0] rot_01_o,
  output logic signed [TRIG_W-1:0] rot_02_o,
  output logic signed [TRIG_W-1:0] rot_10_o,
  output logic signed [TRIG_W-1:0] rot_11_o,
  output logic signed [TRIG_W-1:0] rot_12_o,
  output logic signed [TRIG_W-1:0] rot_21_o,
  output logic signed [TRIG_W-1:0] rot_22_o,
  output logic signed [LEN_W-1:0]  pos_x_o,
  output logic signed [LEN_W-1:0]  pos_y_o,
  output logic signed [LEN_W-1:0]  pos_z_o
);

  logic signed [LEN_W-1:0] joint_offset_q;
  logic signed [LEN_W-1:0] link_length_q;
  logic signed [ANG_W-1:0] link_twist_q;

  logic        chain_valid [CORDIC_STEPS+1];
  logic        chain_ready [CORDIC_STEPS+1];
  dhl_pair_t   chain_data  [CORDIC_STEPS+1];
  dhl_result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joint_offset_q <= '0;
      link_length_q  <= '0;
      link_twist_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_JOINT_OFFSET: joint_offset_q <= cfg_data_i[LEN_W-1:0];
        REG_LINK_LENGTH:  link_length_q  <= cfg_data_i[LEN_W-1:0];
        REG_LINK_TWIST:   link_twist_q   <= cfg_data_i[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  dhl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .joint_angle_i (joint_angle_i),
    .link_twist_i  (link_twist_q),
    .out_valid_o   (chain_valid[0]),
    .out_ready_i   (chain_ready[0]),
    .out_data_o    (chain_data[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    dhl_cordic_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (STEP_W'(k)),
      .atan_i      (dhl_atan(5'(k))),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_data_i   (chain_data[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_data_o  (chain_data[k+1])
    );
  end

  dhl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (chain_valid[CORDIC_STEPS]),
    .in_ready_o    (chain_ready[CORDIC_STEPS]),
    .in_data_i     (chain_data[CORDIC_STEPS]),
    .link_length_i (link_length_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (res)
  );

  assign rot_00_o = res.rot_00;
  assign rot_01_o = res.rot_01;
  assign rot_02_o = res.rot_02;
  assign rot_10_o = res.rot_10;
  assign rot_11_o = res.rot_11;
  assign rot_12_o = res.rot_12;
  assign rot_21_o = res.rot_21;
  assign rot_22_o = res.rot_22;
  assign pos_x_o  = res.pos_x;
  assign pos_y_o  = res.pos_y;
  assign pos_z_o  = joint_offset_q;

endmodule

### hw/rtl/dhl_front.sv
// dhl_front: input stage, folds joint angle and twist into the CORDIC range.
// Depends on dhl_pkg.
module dhl_front import dhl_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ANG_W-1:0]  joint_angle_i,
  input  logic signed [ANG_W-1:0]  link_twist_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output dhl_pair_t                out_data_o
);

  logic      valid_q;
  dhl_pair_t data_q;
  dhl_pair_t data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    data_d.th = dhl_reduce(joint_angle_i);
    data_d.al = dhl_reduce(link_twist_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### hw/rtl/dhl_cordic_cell.sv
// dhl_cordic_cell: one CORDIC micro-rotation for both angle lanes, registered.
// Depends on dhl_pkg.
module dhl_cordic_cell import dhl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [STEP_W-1:0]       step_i,
  input  logic signed [CW-1:0]    atan_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  dhl_pair_t               in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output dhl_pair_t               out_data_o
);

  logic      valid_q;
  dhl_pair_t data_q;
  dhl_pair_t data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    data_d.th = dhl_rotate(in_data_i.th, step_i, atan_i);
    data_d.al = dhl_rotate(in_data_i.al, step_i, atan_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### hw/rtl/dhl_back.sv
// dhl_back: rounding stage to Q1.14, then product stage and output register.
// Depends on dhl_pkg.
module dhl_back import dhl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  dhl_pair_t               in_data_i,
  input  logic signed [LEN_W-1:0] link_length_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output dhl_result_t             out_data_o
);

  logic                     rnd_valid_q;
  logic                     rnd_ready;
  logic signed [TRIG_W-1:0] st_q;
  logic signed [TRIG_W-1:0] ct_q;
  logic signed [TRIG_W-1:0] sa_q;
  logic signed [TRIG_W-1:0] ca_q;
  logic                     res_valid_q;
  dhl_result_t              res_q;
  dhl_result_t              res_d;

  assign rnd_ready  = !res_valid_q || out_ready_i;
  assign in_ready_o = !rnd_valid_q || rnd_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        rnd_valid_q <= in_valid_i;
      end
      if (rnd_ready) begin
        res_valid_q <= rnd_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      st_q <= dhl_round_trig(in_data_i.th.y, in_data_i.th.neg);
      ct_q <= dhl_round_trig(in_data_i.th.x, in_data_i.th.neg);
      sa_q <= dhl_round_trig(in_data_i.al.y, in_data_i.al.neg);
      ca_q <= dhl_round_trig(in_data_i.al.x, in_data_i.al.neg);
    end
  end

  always_comb begin
    res_d.rot_00 = ct_q;
    res_d.rot_01 = dhl_rot_mul(st_q, ca_q, 1'b1);
    res_d.rot_02 = dhl_rot_mul(st_q, sa_q, 1'b0);
    res_d.rot_10 = st_q;
    res_d.rot_11 = dhl_rot_mul(ct_q, ca_q, 1'b0);
    res_d.rot_12 = dhl_rot_mul(ct_q, sa_q, 1'b1);
    res_d.rot_21 = sa_q;
    res_d.rot_22 = ca_q;
    res_d.pos_x  = dhl_len_mul(link_length_i, ct_q);
    res_d.pos_y  = dhl_len_mul(link_length_i, st_q);
  end

  always_ff @(posedge clk_i) begin
    if (rnd_ready && rnd_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule
